// File: design/rasp_pkg.sv
// ----------------------------------------------------------------------------
// rasp_pkg
// Shared types and constants for the RESP array stream parser: item
// structs, parse phase encoding, status codes and framing characters.
// ----------------------------------------------------------------------------
package rasp_pkg;

	// Input item: one message byte plus end-of-message flag
	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_end;
	} item_t;

	// Result item: one per input byte
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        payload_valid;
		logic [31:0] element_index;
		logic        element_done;
		logic        array_complete;
		logic        msg_done;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [3:0] {
		PH_STAR     = 4'd0,
		PH_CNT_DIG  = 4'd1,
		PH_CNT_LF   = 4'd2,
		PH_DOLLAR   = 4'd3,
		PH_LEN_DIG  = 4'd4,
		PH_LEN_LF   = 4'd5,
		PH_PAYLOAD  = 4'd6,
		PH_TRAIL_CR = 4'd7,
		PH_TRAIL_LF = 4'd8,
		PH_DONE     = 4'd9,
		PH_ERROR    = 4'd10
	} phase_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MALFORM  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

// File: design/resp_array_stream_parser_core.sv
// ----------------------------------------------------------------------------
// resp_array_stream_parser_core
// Byte-stream parser for RESP arrays of bulk strings with per-byte results.
// ----------------------------------------------------------------------------
// The block takes one message byte per item, with msg_end set on the last
// byte, and returns exactly one result item per input item, in order. It
// checks the framing '*' <count> CRLF, then per element '$' <length> CRLF,
// the payload bytes and CRLF. Payload bytes come out with payload_valid and
// their zero-based element_index; the closing LF of each element raises
// element_done, and the byte that finishes the array raises array_complete.
// On the msg_end byte, msg_done is set and status reads ok (0), malformed or
// truncated (1), or count/length overflow (2), and the parser returns to its
// start state for the next message. Bytes after a complete array or an error
// are dropped, with a zero result unless msg_end is set. Counts and lengths
// are NUMBER_WIDTH bits wide (8 to 64); element_index shows the low 32 bits.
// Throughput is one item per clock while results are taken. An accepted
// item sits in the input register while the phase and counter update runs,
// and its result is loaded into the result register once the result slot
// is free or being emptied, and is offered from there until it is taken.
// While a result waits unaccepted, the input register still takes one more
// item, and then the input stalls until the result is taken.
// ----------------------------------------------------------------------------
module resp_array_stream_parser_core #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rasp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output rasp_pkg::result_t result
);
	import rasp_pkg::*;

	// Input register stage
	item_t   item_s1;
	logic    valid_s1;

	// Result register
	result_t result_q;
	logic    result_valid_q;

	result_t res;
	logic    advance;

	// Move the staged byte through the parser whenever the result slot is
	// free or being emptied this cycle
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	rasp_parse #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.item  (item_s1),
		.res   (res)
	);

	// Hold the accepted item until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: design/rasp_parse.sv
// ----------------------------------------------------------------------------
// rasp_parse
// Parse state and per-byte framing logic. Consumes one byte when enabled,
// updates the phase and counters, and produces the matching result item.
// ----------------------------------------------------------------------------
module rasp_parse #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rasp_pkg::item_t   item,
	output rasp_pkg::result_t res
);
	import rasp_pkg::*;

	localparam int NW = NUMBER_WIDTH;

	phase_t          phase_q, phase_n;
	logic [NW-1:0]   left_q, left_n;
	logic [NW-1:0]   cnt_q, cnt_n;
	logic [NW-1:0]   acc_q, acc_n;
	logic [NW-1:0]   pay_q, pay_n;
	logic [1:0]      err_q, err_n;

	logic [NW+3:0]   acc_ext;
	logic [NW+3:0]   acc_x10;
	logic            acc_ovf;
	logic            is_digit;
	logic [7:0]      b;
	logic [NW-1:0]   left_dec;
	logic [NW-1:0]   pay_dec;

	assign b        = item.in_byte;
	assign acc_ext  = {4'b0, acc_q};
	// acc * 10 + digit, four spare bits catch overflow
	assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + (NW+4)'(b[3:0]);
	assign acc_ovf  = |acc_x10[NW+3:NW];
	assign left_dec = left_q - NW'(1);
	assign pay_dec  = pay_q - NW'(1);

	always_comb begin
		is_digit = b inside {[CH_ZERO:CH_NINE]};
		phase_n  = phase_q;
		left_n   = left_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		pay_n    = pay_q;
		err_n    = err_q;
		res      = '0;

		case (phase_q)
			PH_STAR: begin
				if (b == CH_STAR) begin
					acc_n   = '0;
					phase_n = PH_CNT_DIG;
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_CNT_DIG, PH_LEN_DIG: begin
				if (is_digit) begin
					if (acc_ovf) begin
						err_n   = ST_OVERFLOW;
						phase_n = PH_ERROR;
					end else begin
						acc_n = acc_x10[NW-1:0];
					end
				end else if (b == CH_CR) begin
					phase_n = (phase_q == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_CNT_LF: begin
				if (b == CH_LF) begin
					left_n = acc_q;
					acc_n  = '0;
					cnt_n  = '0;
					if (acc_q == '0) begin
						phase_n            = PH_DONE;
						res.array_complete = 1'b1;
					end else begin
						phase_n = PH_DOLLAR;
					end
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_DOLLAR: begin
				if (b == CH_DOLLAR) begin
					acc_n   = '0;
					phase_n = PH_LEN_DIG;
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_LEN_LF: begin
				if (b == CH_LF) begin
					pay_n   = acc_q;
					acc_n   = '0;
					phase_n = (acc_q != '0) ? PH_PAYLOAD : PH_TRAIL_CR;
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_PAYLOAD: begin
				res.out_byte      = b;
				res.payload_valid = 1'b1;
				res.element_index = 32'(cnt_q);
				pay_n             = pay_dec;
				if (pay_dec == '0) begin
					phase_n = PH_TRAIL_CR;
				end
			end
			PH_TRAIL_CR: begin
				if (b == CH_CR) begin
					phase_n = PH_TRAIL_LF;
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			PH_TRAIL_LF: begin
				if (b == CH_LF) begin
					res.element_done  = 1'b1;
					res.element_index = 32'(cnt_q);
					cnt_n             = cnt_q + NW'(1);
					left_n            = left_dec;
					if (left_dec == '0) begin
						phase_n            = PH_DONE;
						res.array_complete = 1'b1;
					end else begin
						phase_n = PH_DOLLAR;
					end
				end else begin
					err_n   = ST_MALFORM;
					phase_n = PH_ERROR;
				end
			end
			default: begin
				// done or error: drop the byte
			end
		endcase

		// Message end: report status and return to the start state
		if (item.msg_end) begin
			res.msg_done = 1'b1;
			if (err_n != ST_OK) begin
				res.status = err_n;
			end else if (phase_n != PH_DONE) begin
				res.status = ST_MALFORM;
			end else begin
				res.status = ST_OK;
			end
			phase_n = PH_STAR;
			left_n  = '0;
			cnt_n   = '0;
			acc_n   = '0;
			pay_n   = '0;
			err_n   = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			left_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			pay_q   <= '0;
			err_q   <= ST_OK;
		end else if (en) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			pay_q   <= pay_n;
			err_q   <= err_n;
		end
	end

endmodule
